// File: hw/rtl/lse_pkg.sv
// Shared types and constants for the Legendre series evaluator.
// Holds the transaction structs, Q2.30 constants and Bonnet coefficient tables.
// No dependencies; every other file in hw/rtl uses this package.
package lse_pkg;

    localparam int FRAC_W = 30;
    localparam int VAL_W  = 32;
    localparam int DEG_W  = 4;
    localparam int DEG_LIMIT = 15;

    localparam logic signed [VAL_W-1:0] ONE_Q     = 32'sh4000_0000;
    localparam logic signed [VAL_W-1:0] NEG_ONE_Q = -32'sh4000_0000;

    // Input transaction: one sample point.
    typedef struct packed {
        logic signed [VAL_W-1:0] point_value;
        logic                    end_of_batch;
    } point_t;

    // Output transaction: one polynomial value.
    typedef struct packed {
        logic [DEG_W-1:0]        degree;
        logic signed [VAL_W-1:0] poly_value;
        logic                    last_of_point;
        logic                    batch_end;
    } result_t;

    // Per-point side data that travels down the pipeline.
    typedef struct packed {
        logic signed [VAL_W-1:0] x;      // clamped sample point
        logic signed [VAL_W-1:0] t;      // (a_n * x) >>> 30 for the next step
        logic [DEG_W-1:0]        order;  // highest degree to emit
        logic                    eob;    // end-of-batch mark
    } side_t;

    // b_n = (n-1)/n in Q2.30, rounded, for the step that produces P_n.
    function automatic logic signed [VAL_W-1:0] coef_b(input int n);
        logic signed [VAL_W-1:0] b;
        unique case (n)
            2:       b = 32'sd536870912;
            3:       b = 32'sd715827883;
            4:       b = 32'sd805306368;
            5:       b = 32'sd858993459;
            6:       b = 32'sd894784853;
            7:       b = 32'sd920350135;
            8:       b = 32'sd939524096;
            9:       b = 32'sd954437177;
            10:      b = 32'sd966367642;
            11:      b = 32'sd976128931;
            12:      b = 32'sd984263339;
            13:      b = 32'sd991146299;
            14:      b = 32'sd997045979;
            15:      b = 32'sd1002159036;
            default: b = '0;
        endcase
        return b;
    endfunction

    // a_n = (2n-1)/n in Q2.30; rounding makes it exactly b_n + 1.0.
    function automatic logic signed [VAL_W-1:0] coef_a(input int n);
        logic signed [VAL_W-1:0] b;
        b = coef_b(n);
        return (b == '0) ? '0 : b + ONE_Q;
    endfunction

endpackage

// File: hw/rtl/lse_front.sv
// Front stage of the Legendre evaluator: clamps x, latches order, seeds the recurrence.
// Produces P_0 and P_1 and the first scaled coefficient term.
// Depends on lse_pkg.
module lse_front #(
    parameter int NSTEP = 15
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  lse_pkg::point_t               point,
    input  logic [lse_pkg::DEG_W-1:0]     max_degree,
    output logic                          valid,
    output lse_pkg::side_t                side,
    output logic [2*lse_pkg::VAL_W-1:0]   vals
);

    localparam logic [lse_pkg::DEG_W-1:0] ORDER_CAP = lse_pkg::DEG_W'(NSTEP);

    logic                                valid_reg;
    lse_pkg::side_t                      side_reg;
    lse_pkg::side_t                      side_next;
    logic signed [lse_pkg::VAL_W-1:0]    xc;
    logic signed [2*lse_pkg::VAL_W-1:0]  prod_t;

    // Clamp the point to [-1, +1] and form the first coefficient term.
    always_comb
    begin
        priority if (point.point_value > lse_pkg::ONE_Q)
            xc = lse_pkg::ONE_Q;
        else if (point.point_value < lse_pkg::NEG_ONE_Q)
            xc = lse_pkg::NEG_ONE_Q;
        else
            xc = point.point_value;
        prod_t = lse_pkg::coef_a(2) * xc;
        side_next.x     = xc;
        side_next.t     = prod_t[lse_pkg::FRAC_W+lse_pkg::VAL_W-1:lse_pkg::FRAC_W];
        side_next.order = (max_degree > ORDER_CAP) ? ORDER_CAP : max_degree;
        side_next.eob   = point.end_of_batch;
    end

    // Advance the valid bit with the enable.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // Hold the payload unless the pipeline advances.
    always_ff @(posedge clk)
    begin
        if (en)
            side_reg <= side_next;
    end

    assign valid = valid_reg;
    assign side  = side_reg;
    // P_1 sits above P_0.
    assign vals  = {side_reg.x, lse_pkg::ONE_Q};

endmodule

// File: hw/rtl/lse_step.sv
// One Bonnet recurrence step: produces P_DEG from P_(DEG-1) and P_(DEG-2).
// Two register stages: products, then subtract and saturate. Depends on lse_pkg.
module lse_step #(
    parameter int DEG = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               valid_in,
    input  lse_pkg::side_t                     side_in,
    input  logic [DEG*lse_pkg::VAL_W-1:0]      vals_in,
    output logic                               valid_out,
    output lse_pkg::side_t                     side_out,
    output logic [(DEG+1)*lse_pkg::VAL_W-1:0]  vals_out
);

    localparam int VW = lse_pkg::VAL_W;
    localparam int FW = lse_pkg::FRAC_W;
    localparam logic signed [VW-1:0] COEF_B  = lse_pkg::coef_b(DEG);
    localparam logic signed [VW-1:0] COEF_AN = lse_pkg::coef_a(DEG + 1);

    logic signed [VW-1:0]     cur;
    logic signed [VW-1:0]     prev;
    logic signed [2*VW-1:0]   prod1;
    logic signed [2*VW-1:0]   prod2;
    logic signed [2*VW-1:0]   prod3;
    lse_pkg::side_t           side_a_next;

    logic                     valid_a_reg;
    lse_pkg::side_t           side_a_reg;
    logic [DEG*VW-1:0]        vals_a_reg;
    logic signed [VW:0]       p1_a_reg;
    logic signed [VW-1:0]     p2_a_reg;

    logic signed [VW+1:0]     diff;
    logic signed [VW-1:0]     val_sat;

    logic                     valid_b_reg;
    lse_pkg::side_t           side_b_reg;
    logic [(DEG+1)*VW-1:0]    vals_b_reg;

    // Form the products; the next coefficient term is prepared alongside.
    always_comb
    begin
        cur   = vals_in[(DEG-1)*VW +: VW];
        prev  = vals_in[(DEG-2)*VW +: VW];
        prod1 = side_in.t * cur;
        prod2 = COEF_B * prev;
        prod3 = COEF_AN * side_in.x;
        side_a_next   = side_in;
        side_a_next.t = prod3[FW+VW-1:FW];
    end

    // Subtract and saturate to [-1, +1].
    always_comb
    begin
        diff = (VW+2)'(p1_a_reg) - (VW+2)'(p2_a_reg);
        priority if (diff > (VW+2)'(lse_pkg::ONE_Q))
            val_sat = lse_pkg::ONE_Q;
        else if (diff < (VW+2)'(lse_pkg::NEG_ONE_Q))
            val_sat = lse_pkg::NEG_ONE_Q;
        else
            val_sat = diff[VW-1:0];
    end

    // Advance the valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= valid_in;
            valid_b_reg <= valid_a_reg;
        end
    end

    // Hold the payload unless the pipeline advances.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_a_reg <= side_a_next;
            vals_a_reg <= vals_in;
            p1_a_reg   <= prod1[FW+VW:FW];
            p2_a_reg   <= prod2[FW+VW-1:FW];
            side_b_reg <= side_a_reg;
            vals_b_reg <= {val_sat, vals_a_reg};
        end
    end

    assign valid_out = valid_b_reg;
    assign side_out  = side_b_reg;
    assign vals_out  = vals_b_reg;

endmodule

// File: hw/rtl/lse_serial.sv
// Result serializer: takes a finished point and emits one value per cycle while result_ready is high.
// Ends in an output register so a new point loads while results drain. Depends on lse_pkg.
module lse_serial #(
    parameter int NSTEP = 15
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tail_valid,
    input  lse_pkg::side_t                      tail_side,
    input  logic [(NSTEP+1)*lse_pkg::VAL_W-1:0] tail_vals,
    output logic                                load,
    output logic                                result_valid,
    input  logic                                result_ready,
    output lse_pkg::result_t                    result
);

    localparam int VW    = lse_pkg::VAL_W;
    localparam int IDX_W = (NSTEP + 1 > 1) ? $clog2(NSTEP + 1) : 1;

    logic                              busy_reg;
    logic [IDX_W-1:0]                  cnt_reg;
    logic [IDX_W-1:0]                  order_reg;
    logic                              eob_reg;
    logic signed [VW-1:0]              vals_reg [0:NSTEP];
    logic                              out_valid_reg;
    lse_pkg::result_t                  out_reg;

    logic                              out_free;
    logic                              issue;
    logic                              last_issue;
    lse_pkg::result_t                  out_next;

    // Issue the next value when the output register frees up.
    always_comb
    begin
        out_free   = !out_valid_reg || result_ready;
        issue      = busy_reg && out_free;
        last_issue = issue && (cnt_reg == order_reg);
        load       = tail_valid && (!busy_reg || last_issue);
        out_next.degree        = lse_pkg::DEG_W'(cnt_reg);
        out_next.poly_value    = vals_reg[cnt_reg];
        out_next.last_of_point = (cnt_reg == order_reg);
        out_next.batch_end     = (cnt_reg == order_reg) && eob_reg;
    end

    // Track the point in flight and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                busy_reg <= 1'b1;
            else if (last_issue)
                busy_reg <= 1'b0;

            if (load)
                cnt_reg <= '0;
            else if (issue)
                cnt_reg <= cnt_reg + 1'b1;

            if (issue)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Capture a finished point and the outgoing value.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            order_reg <= tail_side.order[IDX_W-1:0];
            eob_reg   <= tail_side.eob;
            for (int i = 0; i <= NSTEP; i++)
                vals_reg[i] <= tail_vals[i*VW +: VW];
        end
        if (issue)
            out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// File: hw/rtl/legendre_series_eval_top.sv
// Legendre series evaluator: for each sample point x (Q2.30) emits P_0(x) .. P_N(x)
// in rising degree order, N = min(max_degree, MAX_ORDER, 15), one result per cycle while
// result_ready is high. The result serializer sets the point rate in steady state, since
// the pipeline stalls while a finished point waits for it. Behind it a pipeline of
// 1 + 2*(MIN(MAX_ORDER,15)-1) register stages (one multiply stage and one subtract and
// saturate stage per recurrence step) holds several points at once. max_degree (reset 4)
// is written through the cfg channel, which is always ready, and should only change while
// the block is idle.
// Depends on lse_pkg, lse_front, lse_step and lse_serial.
module legendre_series_eval_top #(
    parameter int MAX_ORDER = 15
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          point_valid,
    output logic                          point_ready,
    input  lse_pkg::point_t               point,
    output logic                          result_valid,
    input  logic                          result_ready,
    output lse_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lse_pkg::DEG_W-1:0]     cfg_data
);

    localparam int NSTEP = (MAX_ORDER < lse_pkg::DEG_LIMIT) ? MAX_ORDER : lse_pkg::DEG_LIMIT;
    localparam int VW    = lse_pkg::VAL_W;
    localparam int VECW  = (NSTEP + 1) * VW;

    logic [lse_pkg::DEG_W-1:0]  max_degree_reg;
    logic                       en;
    logic                       load;
    logic                       valid_w [1:NSTEP];
    lse_pkg::side_t             side_w  [1:NSTEP];
    logic [VECW-1:0]            vals_w  [1:NSTEP];

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_degree_reg <= lse_pkg::DEG_W'(4);
        else if (cfg_valid)
            max_degree_reg <= cfg_data;
    end

    assign cfg_ready = 1'b1;

    // Advance the whole pipeline unless a finished point waits on the serializer.
    assign en          = !valid_w[NSTEP] || load;
    assign point_ready = en;

    lse_front #(
        .NSTEP (NSTEP)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (point_valid),
        .point      (point),
        .max_degree (max_degree_reg),
        .valid      (valid_w[1]),
        .side       (side_w[1]),
        .vals       (vals_w[1][2*VW-1:0])
    );

    if (NSTEP > 1)
    begin : g_front_pad
        assign vals_w[1][VECW-1:2*VW] = '0;
    end

    // One recurrence step per degree above one.
    for (genvar n = 2; n <= NSTEP; n++)
    begin : g_step
        lse_step #(
            .DEG (n)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (valid_w[n-1]),
            .side_in   (side_w[n-1]),
            .vals_in   (vals_w[n-1][n*VW-1:0]),
            .valid_out (valid_w[n]),
            .side_out  (side_w[n]),
            .vals_out  (vals_w[n][(n+1)*VW-1:0])
        );

        if (n < NSTEP)
        begin : g_pad
            assign vals_w[n][VECW-1:(n+1)*VW] = '0;
        end
    end

    lse_serial #(
        .NSTEP (NSTEP)
    ) u_serial (
        .clk          (clk),
        .rst_n        (rst_n),
        .tail_valid   (valid_w[NSTEP]),
        .tail_side    (side_w[NSTEP]),
        .tail_vals    (vals_w[NSTEP]),
        .load         (load),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// File: tb/tb.sv
// Self-checking bench for legendre_series_eval_top: Bonnet recurrence values per point.
// Predicts every P_n(x) in Q2.30 and checks each result under random valid/ready idling.
// Depends on lse_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps

module tb;

    localparam int     ORDER_CAP   = 15;
    localparam longint UNIT        = 64'sd1 <<< lse_pkg::FRAC_W;
    localparam int     CYCLE_LIMIT = 400_000;
    localparam int     DRAIN_WAIT  = 40;
    localparam int     PHASE_ITEMS = 35;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      point_valid;
    logic                      point_ready;
    lse_pkg::point_t           point;
    logic                      result_valid;
    logic                      result_ready;
    lse_pkg::result_t          result;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [lse_pkg::DEG_W-1:0] cfg_data;

    // Bench state
    lse_pkg::point_t           points_pending[$];
    lse_pkg::result_t          poly_expected[$];
    logic [lse_pkg::DEG_W-1:0] degree_cfg;
    int                        points_queued;
    int                        points_taken;
    int                        mismatches;
    int                        cycle_count;
    int                        send_gap;
    int                        recv_gap;
    bit                        point_fire;
    bit                        calm;

    legendre_series_eval_top #(.MAX_ORDER(ORDER_CAP)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .point        (point),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // round(num * 2^30 / den), ties up
    function automatic longint bonnet_coef(input longint num, input longint den);
        return ((num <<< lse_pkg::FRAC_W) + den / 2) / den;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > UNIT)
            return UNIT;
        if (v < -UNIT)
            return -UNIT;
        return v;
    endfunction

    // Work out P_0 .. P_order for one accepted point and queue them
    task automatic predict_legendre(input lse_pkg::point_t pt);
        longint           x;
        longint           prev;
        longint           cur;
        longint           val;
        longint           a;
        longint           b;
        longint           t;
        int               order;
        lse_pkg::result_t r;
        x = clamp_unit(longint'($signed(pt.point_value)));
        order = (int'(degree_cfg) > ORDER_CAP) ? ORDER_CAP : int'(degree_cfg);
        prev = 0;
        cur = UNIT;
        for (int n = 0; n <= order; n++)
        begin
            if (n == 0)
                val = UNIT;
            else if (n == 1)
            begin
                val = x;
                prev = UNIT;
                cur = x;
            end
            else
            begin
                a = bonnet_coef(2 * n - 1, n);
                b = bonnet_coef(n - 1, n);
                t = (a * x) >>> lse_pkg::FRAC_W;
                val = clamp_unit(((t * cur) >>> lse_pkg::FRAC_W)
                                 - ((b * prev) >>> lse_pkg::FRAC_W));
                prev = cur;
                cur = val;
            end
            r.degree        = lse_pkg::DEG_W'(n);
            r.poly_value    = val[31:0];
            r.last_of_point = (n == order);
            r.batch_end     = (n == order) ? pt.end_of_batch : 1'b0;
            poly_expected.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic queue_point(input logic [31:0] v, input logic eob);
        lse_pkg::point_t p;
        p.point_value  = v;
        p.end_of_batch = eob;
        points_pending.push_back(p);
        points_queued++;
    endtask

    // Mostly in [-1,1], some exact extremes, some raw words that need clamping
    task automatic queue_random_point();
        longint      v;
        logic [31:0] w;
        int          pick;
        pick = $urandom_range(99, 0);
        if (pick < 78)
        begin
            v = longint'($urandom_range(32'h8000_0000, 0)) - UNIT;
            w = v[31:0];
        end
        else if (pick < 88)
        begin
            case ($urandom_range(3, 0))
                0:       w = 32'h4000_0000;
                1:       w = 32'hC000_0000;
                2:       w = 32'h0000_0000;
                default: w = 32'h3FFF_FFFF;
            endcase
        end
        else
            w = $urandom;
        queue_point(w, ($urandom_range(5, 0) == 0));
    endtask

    // Wait until every queued point is taken and every result has arrived
    task automatic wait_drained();
        @(negedge clk);
        while (points_taken != points_queued || poly_expected.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_degree(input logic [lse_pkg::DEG_W-1:0] d);
        wait_drained();
        cfg_data  <= d;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drive points: hold until accepted, then idle in bursts or send the next one
    always @(negedge clk)
    begin
        if (!rst_n)
            point_valid <= 1'b0;
        else if (point_valid && !point_fire)
            point_valid <= 1'b1;
        else if (send_gap > 0)
        begin
            point_valid <= 1'b0;
            send_gap--;
        end
        else if (points_pending.size() > 0)
        begin
            if (!calm && $urandom_range(5, 0) == 0)
            begin
                send_gap = $urandom_range(14, 1) - 1;
                point_valid <= 1'b0;
            end
            else
            begin
                point       <= points_pending.pop_front();
                point_valid <= 1'b1;
            end
        end
        else
            point_valid <= 1'b0;
    end

    // Stall the result side in bursts
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (recv_gap > 0)
        begin
            result_ready <= 1'b0;
            recv_gap--;
        end
        else if (!calm && $urandom_range(7, 0) == 0)
        begin
            recv_gap = $urandom_range(14, 1) - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    // Sample all handshakes, predict on accepted points, check accepted results
    always @(posedge clk)
    begin
        lse_pkg::result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                degree_cfg = cfg_data;
            point_fire = point_valid && point_ready;
            if (point_fire)
            begin
                points_taken++;
                predict_legendre(point);
            end
            if (result_valid && result_ready)
            begin
                if (poly_expected.size() == 0)
                    report_mismatch($sformatf("unexpected result degree %0d value %h",
                                              result.degree, result.poly_value));
                else
                begin
                    want = poly_expected.pop_front();
                    if (result.degree !== want.degree)
                        report_mismatch($sformatf("degree %0d, want %0d",
                                                  result.degree, want.degree));
                    if (result.poly_value !== want.poly_value)
                        report_mismatch($sformatf("P_%0d value %h, want %h", want.degree,
                                                  result.poly_value, want.poly_value));
                    if (result.last_of_point !== want.last_of_point)
                        report_mismatch($sformatf("P_%0d last_of_point %b, want %b",
                                                  want.degree, result.last_of_point,
                                                  want.last_of_point));
                    if (result.batch_end !== want.batch_end)
                        report_mismatch($sformatf("P_%0d batch_end %b, want %b",
                                                  want.degree, result.batch_end,
                                                  want.batch_end));
                end
            end
        end
    end

    initial
    begin
        logic [lse_pkg::DEG_W-1:0] phase_degree[8];
        rst_n        = 1'b0;
        point_valid  = 1'b0;
        point        = '0;
        result_ready = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        degree_cfg   = 4'd4;
        points_queued = 0;
        points_taken  = 0;
        mismatches    = 0;
        cycle_count   = 0;
        send_gap      = 0;
        recv_gap      = 0;
        point_fire    = 1'b0;
        calm          = 1'b0;
        phase_degree  = '{4'd1, 4'd2, 4'd15, 4'd7, 4'd0, 4'd3, 4'd9, 4'd15};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset degree of four
        queue_point(32'h0000_0000, 1'b0);
        queue_point(32'h4000_0000, 1'b0);
        queue_point(32'hC000_0000, 1'b0);
        queue_point(32'h7FFF_FFFF, 1'b1);

        // Full order: bounds, clamping of out-of-range words, tiny and half values
        write_degree(4'd15);
        queue_point(32'h4000_0000, 1'b0);
        queue_point(32'hC000_0000, 1'b1);
        queue_point(32'h7FFF_FFFF, 1'b0);
        queue_point(32'h8000_0000, 1'b0);
        queue_point(32'h4000_0001, 1'b1);
        queue_point(32'hBFFF_FFFF, 1'b0);
        queue_point(32'h3FFF_FFFF, 1'b0);
        queue_point(32'hC000_0001, 1'b0);
        queue_point(32'h0000_0001, 1'b1);
        queue_point(32'hFFFF_FFFF, 1'b0);
        queue_point(32'h2000_0000, 1'b0);
        queue_point(32'hE000_0000, 1'b1);

        // Order zero: only P_0, carrying the batch mark
        write_degree(4'd0);
        queue_point(32'h1234_5678, 1'b0);
        queue_point(32'hC000_0000, 1'b1);
        queue_point(32'h7FFF_FFFF, 1'b1);
        queue_point(32'h0000_0000, 1'b0);

        // Random phases across several degrees; the last one runs without idling
        for (int ph = 0; ph < 8; ph++)
        begin
            write_degree(ph == 6 ? lse_pkg::DEG_W'($urandom_range(15, 0))
                                 : phase_degree[ph]);
            if (ph == 7)
                calm = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                queue_random_point();
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (poly_expected.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", poly_expected.size()));
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
